/* design/sha_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions shared by the SHA-256 hash block.
// ----------------------------------------------------------------------------
package sha_pkg;

   typedef struct packed {
      logic [7:0] message_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic        digest_last;
   } rsp_type;

   typedef struct packed {
      logic [511:0] data;
      logic         last;
   } blk_type;

   typedef enum logic [1:0] {
      F_DATA,
      F_PAD,
      F_ZERO,
      F_LEN
   } front_state_type;

   typedef enum logic [1:0] {
      C_IDLE,
      C_ROUND,
      C_DONE
   } core_state_type;

   localparam logic [5:0] LAST_BYTE = 6'd63;
   localparam logic [5:0] LEN_START = 6'd56;
   localparam logic [7:0] PAD_BYTE  = 8'h80;

   localparam logic [31:0] HASH_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [31:0] big0(input logic [31:0] v);
      big0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
   endfunction

   function automatic logic [31:0] big1(input logic [31:0] v);
      big1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
   endfunction

   function automatic logic [31:0] sml0(input logic [31:0] v);
      sml0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] sml1(input logic [31:0] v);
      sml1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
   endfunction

endpackage

/* design/sha_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_front
// Packs request bytes into 64-byte blocks, appends padding and length, and
// pushes each finished block into the block queue.
// ----------------------------------------------------------------------------
module sha_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sha_pkg::req_type req_data,
   output logic             blk_push,
   output sha_pkg::blk_type blk_data,
   input  logic             blk_full
);
   import sha_pkg::*;

   front_state_type state_ff, state_in;
   logic [511:0]    buf_ff, buf_in;
   logic [5:0]      fill_ff, fill_in;
   logic [63:0]     cnt_ff, cnt_in;
   logic [63:0]     len_ff, len_in;
   logic [2:0]      lcnt_ff, lcnt_in;

   logic            need_wr;
   logic [7:0]      wr_byte;
   logic            stall;
   logic            do_wr;
   logic            accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_DATA;
         fill_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
      end
      buf_ff  <= buf_in;
      len_ff  <= len_in;
      lcnt_ff <= lcnt_in;
   end

   assign stall    = (fill_ff == LAST_BYTE) && blk_full;
   assign req_full = (state_ff != F_DATA) || stall;
   assign accept   = req_push && !req_full;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      lcnt_in  = lcnt_ff;
      need_wr  = 1'b0;
      wr_byte  = 8'h00;
      unique case (state_ff)
         F_DATA: begin
            wr_byte = req_data.message_byte;
            need_wr = accept && req_data.byte_present;
            if (accept && req_data.byte_present) begin
               cnt_in = cnt_ff + 64'd8;
            end
            if (accept && req_data.end_of_message) begin
               len_in   = req_data.byte_present ? cnt_ff + 64'd8 : cnt_ff;
               cnt_in   = '0;
               state_in = F_PAD;
            end
         end
         F_PAD: begin
            wr_byte = PAD_BYTE;
            need_wr = 1'b1;
            if (!stall) begin
               state_in = F_ZERO;
            end
         end
         F_ZERO: begin
            if (fill_ff == LEN_START) begin
               lcnt_in  = '0;
               state_in = F_LEN;
            end else begin
               need_wr = 1'b1;
            end
         end
         F_LEN: begin
            wr_byte = len_ff[63 - 8 * lcnt_ff -: 8];
            need_wr = 1'b1;
            if (!stall) begin
               lcnt_in = lcnt_ff + 3'd1;
               if (lcnt_ff == 3'd7) begin
                  state_in = F_DATA;
               end
            end
         end
         default: state_in = F_DATA;
      endcase
   end

   assign do_wr = need_wr && !stall;

   always_comb begin
      buf_in  = buf_ff;
      fill_in = fill_ff;
      if (do_wr) begin
         buf_in[511 - 8 * fill_ff -: 8] = wr_byte;
         fill_in = fill_ff + 6'd1;
      end
   end

   assign blk_push      = do_wr && (fill_ff == LAST_BYTE);
   assign blk_data.data = buf_in;
   assign blk_data.last = (state_ff == F_LEN);

endmodule

/* design/sha_blkq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_blkq
// Two-entry queue of padded blocks between the front end and the core.
// ----------------------------------------------------------------------------
module sha_blkq (
   input  logic             clock,
   input  logic             reset,
   input  logic             blk_push,
   input  sha_pkg::blk_type blk_data,
   output logic             blk_full,
   input  logic             q_pop,
   output logic             q_empty,
   output sha_pkg::blk_type q_head
);
   import sha_pkg::*;

   blk_type    ent_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push;
   logic       do_pop;

   assign blk_full = (cnt_ff == 2'd2);
   assign q_empty  = (cnt_ff == 2'd0);
   assign q_head   = ent_ff[rptr_ff];
   assign do_push  = blk_push && !blk_full;
   assign do_pop   = q_pop && !q_empty;

   always_comb begin
      wptr_in = do_push ? !wptr_ff : wptr_ff;
      rptr_in = do_pop ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (do_push) begin
         ent_ff[wptr_ff] <= blk_data;
      end
   end

endmodule

/* design/sha_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_core
// Runs the 64-round compression one round per cycle and delivers the
// digest as four 64-bit words.
// ----------------------------------------------------------------------------
module sha_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  sha_pkg::blk_type q_head,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   core_state_type state_ff, state_in;
   logic [31:0]    h_ff [8];
   logic [31:0]    h_in [8];
   logic [31:0]    v_ff [8];
   logic [31:0]    v_in [8];
   logic [31:0]    w_ff [16];
   logic [31:0]    w_in [16];
   logic [5:0]     rnd_ff, rnd_in;
   logic           last_ff, last_in;
   logic [255:0]   dig_ff, dig_in;
   logic           dval_ff, dval_in;
   logic [1:0]     didx_ff, didx_in;

   logic [31:0]    t1;
   logic [31:0]    t2;
   logic [31:0]    wnew;
   logic [31:0]    hsum [8];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         dval_ff  <= 1'b0;
         h_ff     <= HASH_IV;
      end else begin
         state_ff <= state_in;
         dval_ff  <= dval_in;
         h_ff     <= h_in;
      end
      v_ff    <= v_in;
      w_ff    <= w_in;
      rnd_ff  <= rnd_in;
      last_ff <= last_in;
      dig_ff  <= dig_in;
      didx_ff <= didx_in;
   end

   always_comb begin
      t1 = v_ff[7] + big1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + ROUND_K[rnd_ff] + w_ff[0];
      t2 = big0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      wnew = sml1(w_ff[14]) + w_ff[9] + sml0(w_ff[1]) + w_ff[0];
      for (int i = 0; i < 8; i++) begin
         hsum[i] = h_ff[i] + v_ff[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      h_in     = h_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      rnd_in   = rnd_ff;
      last_in  = last_ff;
      dig_in   = dig_ff;
      dval_in  = dval_ff;
      didx_in  = didx_ff;
      q_pop    = 1'b0;

      if (rsp_pop && dval_ff) begin
         didx_in = didx_ff + 2'd1;
         if (didx_ff == 2'd3) begin
            dval_in = 1'b0;
         end
      end

      unique case (state_ff)
         C_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               v_in    = h_ff;
               last_in = q_head.last;
               rnd_in  = '0;
               for (int i = 0; i < 16; i++) begin
                  w_in[i] = q_head.data[511 - 32 * i -: 32];
               end
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[15] = wnew;
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = C_DONE;
            end
         end
         C_DONE: begin
            if (!(last_ff && dval_ff)) begin
               if (last_ff) begin
                  for (int i = 0; i < 8; i++) begin
                     dig_in[255 - 32 * i -: 32] = hsum[i];
                  end
                  dval_in = 1'b1;
                  didx_in = '0;
                  h_in    = HASH_IV;
               end else begin
                  h_in = hsum;
               end
               state_in = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

   assign rsp_empty            = !dval_ff;
   assign rsp_data.digest_word = dig_ff[255 - 64 * didx_ff -: 64];
   assign rsp_data.digest_last = (didx_ff == 2'd3);

endmodule

/* design/sha256_message_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_hash
// SHA-256 over a byte stream: front end packs and pads, core compresses.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle while the front collects data; it holds
// req_full during padding and length, and while a full block waits for room in
// the two-entry block queue.
// The core handles one block at a time: load, 64 rounds, hash update.
// The first digest word follows the update of the message's last block.
// Reset (synchronous) clears control and restores the initial hash values.
module sha256_message_hash (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sha_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   logic    blk_push;
   blk_type blk_data;
   logic    blk_full;
   logic    q_pop;
   logic    q_empty;
   blk_type q_head;

   sha_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .blk_push (blk_push),
      .blk_data (blk_data),
      .blk_full (blk_full)
   );

   sha_blkq u_blkq (
      .clock    (clock),
      .reset    (reset),
      .blk_push (blk_push),
      .blk_data (blk_data),
      .blk_full (blk_full),
      .q_pop    (q_pop),
      .q_empty  (q_empty),
      .q_head   (q_head)
   );

   sha_core u_core (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* test/sha256_message_hash_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_hash_tb
// Self-checking bench for the byte-stream SHA-256 hash block. A local digest
// model runs beside the block. Every digest word that leaves the block is
// checked against the model's queue. Random idle bursts appear on both the
// request side and the result side.
// ----------------------------------------------------------------------------
module sha256_message_hash_tb;
   import sha_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   sha256_message_hash dut (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_data(req_data), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };
   localparam logic [31:0] KC [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic [31:0] hash_state [8];
   logic [7:0]  block_bytes [64];
   int unsigned fill_count;
   logic [63:0] hashed_bits;
   rsp_type     digest_queue [$];
   int          error_count;
   int          cycle_count;
   bit          idle_enable;
   bit          hold_results;

   function automatic logic [31:0] ror(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   task automatic compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int r = 0; r < 16; r++)
         w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
                 block_bytes[4*r+3]};
      for (int r = 16; r < 64; r++) begin
         s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
         s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
         w[r] = s1 + w[r-7] + s0 + w[r-16];
      end
      v = hash_state;
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KC[r] + w[r];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int r = 0; r < 8; r++) hash_state[r] += v[r];
   endtask

   task automatic predict_digest(req_type rq);
      logic [63:0] total;
      int unsigned i;
      rsp_type     rs;
      if (rq.byte_present) begin
         block_bytes[fill_count] = rq.message_byte;
         fill_count++;
         if (fill_count == 64) begin
            compress();
            hashed_bits += 512;
            fill_count = 0;
         end
      end
      if (rq.end_of_message) begin
         total = hashed_bits + 64'(fill_count) * 8;
         i = fill_count;
         block_bytes[i++] = 8'h80;
         if (i > 56) begin
            while (i < 64) block_bytes[i++] = 8'h00;
            compress();
            i = 0;
         end
         while (i < 56) block_bytes[i++] = 8'h00;
         for (int b = 0; b < 8; b++) block_bytes[63-b] = total[8*b +: 8];
         compress();
         for (int k = 0; k < 4; k++) begin
            rs.digest_word = {hash_state[2*k], hash_state[2*k+1]};
            rs.digest_last = (k == 3);
            digest_queue.insert(digest_queue.size(), rs);
         end
         hash_state = IV;
         fill_count = 0;
         hashed_bits = 0;
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   always begin
      clock = 1'b0; #4;
      clock = 1'b1; #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 900000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // check each popped digest word
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (digest_queue.size() == 0) begin
            report_mismatch("unexpected word", rsp_data.digest_word, 64'd0);
         end else begin
            want = digest_queue.pop_front();
            if (rsp_data.digest_word !== want.digest_word)
               report_mismatch("digest_word", rsp_data.digest_word, want.digest_word);
            if (rsp_data.digest_last !== want.digest_last)
               report_mismatch("digest_last", 64'(rsp_data.digest_last),
                               64'(want.digest_last));
         end
      end
   end

   // pop with random idle bursts; hold while hold_results is set
   initial begin
      int gap;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_pop <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            rsp_pop <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic send_request(logic [7:0] b, logic p, logic e);
      req_type rq;
      int      gap;
      rq.message_byte = b;
      rq.byte_present = p;
      rq.end_of_message = e;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 9);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_digest(rq);
   endtask

   task automatic send_message(int len, bit tail_empty);
      for (int i = 0; i < len; i++)
         send_request(8'($urandom), 1'b1, !tail_empty && i == len - 1);
      if (tail_empty || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'hff, 1'b0, 1'b0);
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h63, 1'b1, 1'b1);
      send_request(8'hff, 1'b1, 1'b1);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'haa, 1'b0, 1'b0);
      send_request(8'h55, 1'b0, 1'b1);
      drain();
   endtask

   task automatic test_block_edges();
      send_message(56, 1'b0);
      send_message(64, 1'b0);
      drain();
   endtask

   task automatic test_backpressure();
      int n;
      hold_results = 1'b1;
      fork
         begin
            n = 0;
            while (n < 1000) begin
               @(posedge clock);
               n++;
            end
            hold_results = 1'b0;
         end
         begin
            for (int m = 0; m < 6; m++) send_message($urandom_range(0, 4), m[0]);
         end
      join
      drain();
   endtask

   task automatic test_random();
      int sent;
      int len;
      bit tail;
      sent = 0;
      while (sent < 15) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(8'($urandom), 1'b0, 1'b0);
            sent++;
         end else begin
            len = $urandom_range(0, 5);
            tail = 1'($urandom_range(0, 1));
            send_message(len, tail);
            sent += len + ((tail || len == 0) ? 1 : 0);
         end
      end
      drain();
   endtask

   task automatic test_no_idle();
      idle_enable = 1'b0;
      for (int m = 0; m < 4; m++) send_message($urandom_range(0, 6), m[0]);
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      error_count = 0;
      cycle_count = 0;
      idle_enable = 1'b1;
      hold_results = 1'b0;
      hash_state = IV;
      fill_count = 0;
      hashed_bits = 0;
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_block_edges();
      test_backpressure();
      test_random();
      test_no_idle();
      repeat (300) @(posedge clock);
      if (error_count == 0 && digest_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
